// ===== src/ftlbc_pkg.sv =====
// Shared types and constants for the frame to luma block cell sampler.
package ftlbc_pkg;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_VIEW_WIDTH   = 2'd2,
    REG_VIEW_HEIGHT  = 2'd3
  } reg_idx_t;

  localparam logic [0:0] KIND_WRITE = 1'b0;
  localparam logic [0:0] KIND_READ  = 1'b1;

  localparam int unsigned QBITS = 11;

  localparam logic [8:0]  W_RED   = 9'd299;
  localparam logic [9:0]  W_GREEN = 10'd587;
  localparam logic [6:0]  W_BLUE  = 7'd114;
  // floor(s/1000) = floor((s>>3) * RECIP_125 >> 22) for s up to 255000
  localparam logic [15:0] RECIP_125 = 16'd33555;

  localparam logic [7:0] LVL1 = 8'd64;
  localparam logic [7:0] LVL2 = 8'd128;
  localparam logic [7:0] LVL3 = 8'd192;
  localparam logic [7:0] LVL4 = 8'd255;

endpackage

// ===== src/ftlbc_ram.sv =====
// Single-port synchronous RAM with registered read.
module ftlbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== src/frame_to_luma_block_cells.sv =====
// Top level of the frame to luma block cell sampler.
// Takes one transaction per cycle, pixel writes and cell reads mixed freely; a read
// answers after the divider, multiply, memory, luma and output registers. Rate is set
// by the single memory port, used once per transaction, and by two 11-stage restoring
// dividers for the source column and row. When the result is held the whole pipeline
// stalls. The pixel store is FRAME_WORDS deep (a power of two); addresses wrap modulo
// its depth. An unwritten pixel reads as anything.
module frame_to_luma_block_cells #(
  parameter int FRAME_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // pixel_address, pixel_rgb, cell_column, cell_row
  input  logic [0:0]  in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // shade_level, red, green, blue
  output logic [0:0]  out_tuser, // cell_valid
  input  logic        cfg_we,
  input  ftlbc_pkg::reg_idx_t cfg_index,
  input  logic [10:0] cfg_wdata
);
  import ftlbc_pkg::*;

  localparam int AW = $clog2(FRAME_WORDS);
  localparam int ND = QBITS;

  logic [10:0] fw_r, fh_r;
  logic [9:0]  vw_r;
  logic [8:0]  vh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 11'd320;
      fh_r <= 11'd200;
      vw_r <= 10'd80;
      vh_r <= 9'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata;
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        REG_VIEW_WIDTH:   vw_r <= cfg_wdata[9:0];
        REG_VIEW_HEIGHT:  vh_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic v_o_r;
  assign adv       = !v_o_r || out_tready;
  assign in_tready = adv;

  logic        i_kind;
  logic [15:0] i_addr;
  logic [23:0] i_rgb;
  logic [8:0]  i_cx;
  logic [7:0]  i_cy;
  logic [8:0]  half_w;
  logic        i_cov;

  assign i_kind = in_tuser[0];
  assign i_addr = in_tdata[15:0];
  assign i_rgb  = in_tdata[39:16];
  assign i_cx   = in_tdata[48:40];
  assign i_cy   = in_tdata[56:49];
  assign half_w = (vw_r[9:1] == 9'd0) ? 9'd1 : vw_r[9:1];
  assign i_cov  = ({1'b0, i_cx} < vw_r) && ({1'b0, i_cy} < vh_r) && ({1'b0, i_cx[8:1]} < half_w);

  // divider pipeline, entry 0 is the input register
  logic        dv_r   [0:ND];
  logic        dk_r   [0:ND];
  logic        dc_r   [0:ND];
  logic [15:0] da_r   [0:ND];
  logic [23:0] dd_r   [0:ND];
  logic [18:0] xrem_r [0:ND];
  logic [18:0] yrem_r [0:ND];
  logic [10:0] xq_r   [0:ND];
  logic [10:0] yq_r   [0:ND];
  logic [18:0] xrem_nxt [0:ND-1];
  logic [18:0] yrem_nxt [0:ND-1];
  logic        xbit [0:ND-1];
  logic        ybit [0:ND-1];

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      logic [19:0] xs, ys;
      xs = 20'(half_w) << (ND - 1 - i);
      ys = 20'(vh_r) << (ND - 1 - i);
      xbit[i] = {1'b0, xrem_r[i]} >= xs;
      ybit[i] = {1'b0, yrem_r[i]} >= ys;
      xrem_nxt[i] = xbit[i] ? 19'({1'b0, xrem_r[i]} - xs) : xrem_r[i];
      yrem_nxt[i] = ybit[i] ? 19'({1'b0, yrem_r[i]} - ys) : yrem_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ND; i++) dv_r[i] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= in_tvalid;
      for (int i = 0; i < ND; i++) dv_r[i+1] <= dv_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dk_r[0]   <= i_kind;
      dc_r[0]   <= i_cov;
      da_r[0]   <= i_addr;
      dd_r[0]   <= i_rgb;
      xrem_r[0] <= i_cx[8:1] * fw_r;
      yrem_r[0] <= i_cy * fh_r;
      xq_r[0]   <= '0;
      yq_r[0]   <= '0;
      for (int i = 0; i < ND; i++) begin
        dk_r[i+1]   <= dk_r[i];
        dc_r[i+1]   <= dc_r[i];
        da_r[i+1]   <= da_r[i];
        dd_r[i+1]   <= dd_r[i];
        xrem_r[i+1] <= xrem_nxt[i];
        yrem_r[i+1] <= yrem_nxt[i];
        xq_r[i+1]   <= {xq_r[i][9:0], xbit[i]};
        yq_r[i+1]   <= {yq_r[i][9:0], ybit[i]};
      end
    end
  end

  // row times width, then address add and memory access
  logic        m_v_r, m_k_r, m_c_r;
  logic [15:0] m_a_r;
  logic [23:0] m_d_r;
  logic [21:0] m_prod_r;
  logic [10:0] m_sx_r;
  logic        r_v_r, r_k_r, r_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      r_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= dv_r[ND];
      r_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_k_r    <= dk_r[ND];
      m_c_r    <= dc_r[ND];
      m_a_r    <= da_r[ND];
      m_d_r    <= dd_r[ND];
      m_prod_r <= yq_r[ND] * fw_r;
      m_sx_r   <= xq_r[ND];
      r_k_r    <= m_k_r;
      r_c_r    <= m_c_r;
    end
  end

  logic [31:0]   rd_idx, wr_idx;
  logic [AW-1:0] ram_addr;
  logic [23:0]   ram_rdata;
  logic          ram_en;

  assign rd_idx   = 32'(m_prod_r) + 32'(m_sx_r);
  assign wr_idx   = 32'(m_a_r);
  assign ram_addr = (m_k_r == KIND_WRITE) ? wr_idx[AW-1:0] : rd_idx[AW-1:0];
  assign ram_en   = adv && m_v_r;

  ftlbc_ram #(
    .WIDTH(24),
    .DEPTH(FRAME_WORDS)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (m_k_r == KIND_WRITE),
    .addr  (ram_addr),
    .wdata (m_d_r),
    .rdata (ram_rdata)
  );

  // luma
  logic        l_v_r, l_c_r, q_v_r, q_c_r;
  logic [23:0] l_rgb_r, q_rgb_r;
  logic [17:0] l_sum_r;
  logic [7:0]  q_lum_r;
  logic [30:0] lum_prod;

  assign lum_prod = 31'(l_sum_r[17:3]) * 31'(RECIP_125);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r <= 1'b0;
      q_v_r <= 1'b0;
    end else if (adv) begin
      l_v_r <= r_v_r && (r_k_r == KIND_READ);
      q_v_r <= l_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_c_r   <= r_c_r;
      l_rgb_r <= ram_rdata;
      l_sum_r <= 18'(ram_rdata[23:16] * W_RED) + 18'(ram_rdata[15:8] * W_GREEN)
               + 18'(ram_rdata[7:0] * W_BLUE);
      q_c_r   <= l_c_r;
      q_rgb_r <= l_rgb_r;
      q_lum_r <= lum_prod[29:22];
    end
  end

  logic [2:0] level;
  always_comb begin
    if (q_lum_r >= LVL4)      level = 3'd4;
    else if (q_lum_r >= LVL3) level = 3'd3;
    else if (q_lum_r >= LVL2) level = 3'd2;
    else if (q_lum_r >= LVL1) level = 3'd1;
    else                      level = 3'd0;
  end

  logic        o_c_r;
  logic [2:0]  o_lvl_r;
  logic [23:0] o_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o_r <= 1'b0;
    end else if (adv) begin
      v_o_r <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_c_r   <= q_c_r;
      o_lvl_r <= q_c_r ? level : 3'd0;
      o_rgb_r <= q_c_r ? q_rgb_r : 24'd0;
    end
  end

  assign out_tvalid = v_o_r;
  assign out_tuser  = o_c_r;
  assign out_tdata  = {5'd0, o_rgb_r[7:0], o_rgb_r[15:8], o_rgb_r[23:16], o_lvl_r};

endmodule
